// ===== hw/rtl/utt_pkg.sv =====
// Package for the UTF-16 to UTF-8 transcoder.
// Holds the code unit and code point constants and the queue entry type.
// No dependencies.
package utt_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;

  localparam logic [UNIT_W-1:0] SURR_HIGH_BASE = 16'hD800;
  localparam logic [UNIT_W-1:0] SURR_LOW_BASE  = 16'hDC00;
  localparam logic [CP_W-1:0]   SUPP_BASE      = 21'h10000;
  localparam logic [CP_W-1:0]   LIMIT_1BYTE    = 21'h7F;
  localparam logic [CP_W-1:0]   LIMIT_2BYTE    = 21'h7FF;
  localparam logic [CP_W-1:0]   LIMIT_3BYTE    = 21'hFFFF;
  localparam logic [CP_W-1:0]   LIMIT_4BYTE    = 21'h10FFFF;
  localparam logic [BYTE_W-1:0] LEAD_2BYTE     = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3BYTE     = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4BYTE     = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MARK      = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_MASK      = 8'h3F;

  // One encoded code point: bytes[0] goes out first, last_idx marks the final byte.
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;
    logic [1:0]             last_idx;
  } utt_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } utt_qstat_t;

endpackage

// ===== hw/rtl/utt_if.sv =====
// Valid/ready channel interfaces for the UTF-16 to UTF-8 transcoder.
// utt_in_if carries code units, utt_out_if carries encoded bytes.
// No dependencies.
interface utt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink (input valid, input code_unit, output ready);
endinterface

interface utt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/utt_front.sv =====
// Front end: accepts code units, pairs surrogates and encodes each code point.
// Depends on utt_pkg and utt_in_if.
module utt_front import utt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  utt_in_if.sink        in_chan,
  input  utt_qstat_t    q_stat,
  output logic          push,
  output utt_entry_t    push_data
);

  logic       pending_r, pending_nxt;
  logic [9:0] high_bits_r, high_bits_nxt;
  logic       in_fire;
  logic       is_high;
  logic [CP_W-1:0] cp;

  function automatic utt_entry_t encode(input logic [CP_W-1:0] c);
    utt_entry_t e;
    e.bytes = '0;
    if (c <= LIMIT_1BYTE) begin
      e.bytes[0] = c[7:0];
      e.last_idx = 2'd0;
    end else if (c <= LIMIT_2BYTE) begin
      e.bytes[0] = LEAD_2BYTE | {3'b000, c[10:6]};
      e.bytes[1] = CONT_MARK | ({2'b00, c[5:0]} & CONT_MASK);
      e.last_idx = 2'd1;
    end else if (c <= LIMIT_3BYTE) begin
      e.bytes[0] = LEAD_3BYTE | {4'b0000, c[15:12]};
      e.bytes[1] = CONT_MARK | ({2'b00, c[11:6]} & CONT_MASK);
      e.bytes[2] = CONT_MARK | ({2'b00, c[5:0]} & CONT_MASK);
      e.last_idx = 2'd2;
    end else begin
      e.bytes[0] = LEAD_4BYTE | {5'b00000, c[20:18]};
      e.bytes[1] = CONT_MARK | ({2'b00, c[17:12]} & CONT_MASK);
      e.bytes[2] = CONT_MARK | ({2'b00, c[11:6]} & CONT_MASK);
      e.bytes[3] = CONT_MARK | ({2'b00, c[5:0]} & CONT_MASK);
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

  assign in_chan.ready = !q_stat.full;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign is_high       = (in_chan.code_unit >= SURR_HIGH_BASE) &&
                         (in_chan.code_unit < SURR_LOW_BASE);

  always_comb begin
    if (pending_r) begin
      cp = {1'b0, high_bits_r, in_chan.code_unit[9:0]} + SUPP_BASE;
    end else begin
      cp = {5'b00000, in_chan.code_unit};
    end
  end

  assign push_data = encode(cp);
  assign push      = in_fire && (pending_r || !is_high);

  always_comb begin
    pending_nxt   = pending_r;
    high_bits_nxt = high_bits_r;
    if (in_fire) begin
      if (pending_r) begin
        pending_nxt   = 1'b0;
        high_bits_nxt = '0;
      end else if (is_high) begin
        pending_nxt   = 1'b1;
        high_bits_nxt = in_chan.code_unit[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      high_bits_r <= '0;
    end else begin
      pending_r   <= pending_nxt;
      high_bits_r <= high_bits_nxt;
    end
  end

endmodule

// ===== hw/rtl/utt_fifo.sv =====
// Short queue of encoded code points between the front and back ends.
// Depends on utt_pkg.
module utt_fifo import utt_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  utt_entry_t push_data,
  input  logic       pop,
  output utt_entry_t head,
  output utt_qstat_t q_stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  utt_entry_t    mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/utt_back.sv =====
// Back end: sends the queued code points out one byte per cycle while the receiver is ready.
// Depends on utt_pkg and utt_out_if.
module utt_back import utt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  utt_entry_t  head,
  input  utt_qstat_t  q_stat,
  output logic        pop,
  utt_out_if.source   out_chan
);

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              last_r, last_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              load;
  logic              at_last;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.last_byte = last_r;

  assign load    = !q_stat.empty && (!out_valid_r || out_chan.ready);
  assign at_last = (idx_r == head.last_idx);
  assign pop     = load && at_last;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_byte_nxt  = out_byte_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = head.bytes[idx_r];
      last_nxt      = at_last;
      idx_nxt       = at_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    last_r     <= last_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

// ===== hw/rtl/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
// Depends on utt_pkg, utt_if, utt_front, utt_fifo and utt_back.
//
//   Channel    Dir  Payload               Transaction
//   in_chan    in   code_unit[15:0]       one UTF-16 code unit
//   out_chan   out  out_byte[7:0],        one UTF-8 byte, last_byte on the
//                   last_byte             final byte of a code point
//
// A code unit produces 0 to 4 bytes; the back end sends one byte per cycle
// while the receiver is ready. The front end accepts a unit every cycle while
// the queue has room; the first byte of a unit passes through the queue and
// then the output register. Reset clears the pending surrogate, the queue and
// the output valid flag. Output stalls fill the queue and then hold off input.
module utf16_to_utf8_transcoder import utt_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  utt_in_if.sink     in_chan,
  utt_out_if.source  out_chan
);

  logic       push;
  logic       pop;
  utt_entry_t push_data;
  utt_entry_t head;
  utt_qstat_t q_stat;

  utt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  utt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  utt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

// ===== test/tb_utf16_to_utf8_transcoder.sv =====
// Testbench for utf16_to_utf8_transcoder: predicts UTF-8 bytes per code unit and checks the output.
// Depends on utt_pkg, the utt_in_if/utt_out_if interfaces and the transcoder RTL.
`timescale 1ns / 1ps

module tb_utf16_to_utf8_transcoder import utt_pkg::*;;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;

  class utf8_byte_scoreboard;
    typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
    } utf8_byte_t;

    bit               high_held;
    bit [9:0]         held_bits;
    utf8_byte_t       expected_bytes[$];
    int               mismatches;

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void push_byte(input logic [BYTE_W-1:0] data, input logic last);
      utf8_byte_t b;
      b.data = data;
      b.last = last;
      expected_bytes.insert(expected_bytes.size(), b);
    endfunction

    function void encode_code_point(input bit [CP_W-1:0] cp);
      if (cp <= LIMIT_1BYTE) begin
        push_byte(cp[7:0], 1'b1);
      end else if (cp <= LIMIT_2BYTE) begin
        push_byte(LEAD_2BYTE | {3'b0, cp[10:6]}, 1'b0);
        push_byte(CONT_MARK | {2'b0, cp[5:0]}, 1'b1);
      end else if (cp <= LIMIT_3BYTE) begin
        push_byte(LEAD_3BYTE | {4'b0, cp[15:12]}, 1'b0);
        push_byte(CONT_MARK | {2'b0, cp[11:6]}, 1'b0);
        push_byte(CONT_MARK | {2'b0, cp[5:0]}, 1'b1);
      end else begin
        push_byte(LEAD_4BYTE | {5'b0, cp[20:18]}, 1'b0);
        push_byte(CONT_MARK | {2'b0, cp[17:12]}, 1'b0);
        push_byte(CONT_MARK | {2'b0, cp[11:6]}, 1'b0);
        push_byte(CONT_MARK | {2'b0, cp[5:0]}, 1'b1);
      end
    endfunction

    // Any unit following a held high surrogate is taken as the low half, unchecked.
    function void note_unit(input logic [UNIT_W-1:0] unit);
      bit [CP_W-1:0] cp;
      if (high_held) begin
        cp = {held_bits, unit[9:0]} + SUPP_BASE;
        high_held = 1'b0;
        held_bits = '0;
        encode_code_point(cp);
      end else if (unit >= SURR_HIGH_BASE && unit < SURR_LOW_BASE) begin
        held_bits = unit[9:0];
        high_held = 1'b1;
      end else begin
        encode_code_point({5'b0, unit});
      end
    endfunction

    task check_byte(input logic [BYTE_W-1:0] data, input logic last);
      utf8_byte_t exp_byte;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %b", data, last));
      end else begin
        exp_byte = expected_bytes.pop_front();
        if (data !== exp_byte.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", data, exp_byte.data));
        if (last !== exp_byte.last)
          report_mismatch($sformatf("last_byte %b, expected %b", last, exp_byte.last));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic rx_hold;

  utf8_byte_scoreboard sb;

  utt_in_if  in_chan();
  utt_out_if out_chan();

  utf16_to_utf8_transcoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_byte(out_chan.out_byte, out_chan.last_byte);
    if (rx_hold)
      out_chan.ready <= 1'b0;
    else
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_unit(input logic [UNIT_W-1:0] unit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid     <= 1'b0;
      in_chan.code_unit <= UNIT_W'($urandom);
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.code_unit <= unit;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_unit(unit);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_bytes.size() != 0);
  endtask

  // Mostly well-formed text with surrogate pairs, plus some raw noise units.
  task automatic send_random_text(input int count);
    int            sent;
    int            pick;
    logic [UNIT_W-1:0] unit;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_unit(UNIT_W'(SURR_HIGH_BASE | $urandom_range(10'h3FF)));
        send_unit(UNIT_W'(SURR_LOW_BASE | $urandom_range(10'h3FF)));
        sent += 2;
      end else begin
        if (pick < 45) begin
          unit = UNIT_W'($urandom_range(16'h007F));
        end else if (pick < 65) begin
          unit = UNIT_W'($urandom_range(16'h07FF, 16'h0080));
        end else if (pick < 85) begin
          unit = UNIT_W'($urandom_range(16'hFFFF, 16'h0800));
          if (unit >= SURR_HIGH_BASE && unit <= 16'hDFFF) unit = unit ^ 16'h4000;
        end else begin
          unit = UNIT_W'($urandom);
        end
        send_unit(unit);
        sent++;
      end
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    send_random_text(count);
    wait_drained();
  endtask

  logic [UNIT_W-1:0] directed_units [$] = '{
    16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF,
    16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF,
    16'hDC00, 16'hDFFF,
    16'hD812, 16'h0041,
    16'hDABC, 16'hD9AB,
    16'hD800, 16'hFFFF
  };

  initial begin
    sb                 = new();
    rst_n              = 1'b0;
    rx_hold            = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    in_chan.valid      = 1'b0;
    in_chan.code_unit  = '0;
    out_chan.ready     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_units[i]) send_unit(directed_units[i]);
    wait_drained();

    run_phase(0, 0, 30);
    run_phase(55, 0, 30);
    run_phase(0, 55, 30);
    run_phase(21, 21, 30);

    // The receiver blocks for a long stretch so the queue fills and input backs up.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_random_text(24);
    wait_drained();

    // A trailing high surrogate stays held and produces nothing.
    send_unit(16'hD83D);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.expected_bytes.size() != 0)
      sb.report_mismatch($sformatf("%0d expected bytes never arrived", sb.expected_bytes.size()));
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
